### sv/bod_pkg.sv
// ----------------------------------------------------------------------------
// bod_pkg
// shared constants, register indexes and the job record passed from the
// front end to the pixel back end of the outline dilation block
// ----------------------------------------------------------------------------
package bod_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int MAX_HEIGHT = 64;

  localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SRC_WIDTH_W  = 5;
  localparam int SRC_HEIGHT_W = 7;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int PIX_W        = 8;
  localparam int OUT_ROW_W    = 7;
  localparam int OUT_COL_W    = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;

  localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RESET  = 5'd8;
  localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RESET = 7'd13;

  localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [MAX_WIDTH-1:0]   older;
    logic [MAX_WIDTH-1:0]   prior;
    logic [MAX_WIDTH-1:0]   cur;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [SRC_WIDTH_W-1:0] width;
    logic                   frame_end;
  } bod_job_t;

endpackage

### sv/bod_front.sv
// ----------------------------------------------------------------------------
// bod_front
// holds geometry registers, the three row coverage masks and the position
// counters; turns each accepted source pixel into one job record
// ----------------------------------------------------------------------------
module bod_front
  import bod_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    pix_take,
  input  logic [PIX_W-1:0]        pix_alpha,
  output bod_job_t                job
);

  logic [SRC_WIDTH_W-1:0]  src_width_r;
  logic [SRC_HEIGHT_W-1:0] src_height_r;
  logic [MAX_WIDTH-1:0]    older_r, older_nxt;
  logic [MAX_WIDTH-1:0]    prior_r, prior_nxt;
  logic [MAX_WIDTH-1:0]    cur_r, cur_nxt;
  logic [COL_W-1:0]        col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]        row_cnt_r, row_cnt_nxt;

  logic [SRC_WIDTH_W-1:0]  w, wm1;
  logic [SRC_HEIGHT_W-1:0] h, hm1;
  logic [MAX_WIDTH-1:0]    wmask, cur_new;
  logic [COL_W-1:0]        c;
  logic [ROW_W-1:0]        r;
  logic                    row_end, frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RESET;
      src_height_r <= SRC_HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SRC_WIDTH) begin
        src_width_r <= cfg_data[SRC_WIDTH_W-1:0];
      end else if (cfg_index == REG_SRC_HEIGHT) begin
        src_height_r <= cfg_data[SRC_HEIGHT_W-1:0];
      end
    end
  end

  // saturated geometry
  always_comb begin
    if (src_width_r == '0) begin
      w = SRC_WIDTH_W'(1);
    end else if (src_width_r > SRC_WIDTH_W'(MAX_WIDTH)) begin
      w = SRC_WIDTH_W'(MAX_WIDTH);
    end else begin
      w = src_width_r;
    end
    if (src_height_r == '0) begin
      h = SRC_HEIGHT_W'(1);
    end else if (src_height_r > SRC_HEIGHT_W'(MAX_HEIGHT)) begin
      h = SRC_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h = src_height_r;
    end
    wm1 = w - SRC_WIDTH_W'(1);
    hm1 = h - SRC_HEIGHT_W'(1);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      wmask[i] = (SRC_WIDTH_W'(i) < w);
    end
  end

  always_comb begin
    c = (SRC_WIDTH_W'(col_cnt_r) < wm1) ? col_cnt_r : wm1[COL_W-1:0];
    r = (SRC_HEIGHT_W'(row_cnt_r) < hm1) ? row_cnt_r : hm1[ROW_W-1:0];
    row_end   = (SRC_WIDTH_W'(c) == wm1);
    frame_end = row_end && (SRC_HEIGHT_W'(r) == hm1);
    cur_new   = cur_r;
    if (pix_alpha != '0) begin
      cur_new = cur_r | (MAX_WIDTH'(1) << c);
    end
  end

  always_comb begin
    job.older     = older_r & wmask;
    job.prior     = prior_r & wmask;
    job.cur       = cur_new & wmask;
    job.row       = r;
    job.col       = c;
    job.width     = w;
    job.frame_end = frame_end;
  end

  always_comb begin
    older_nxt   = older_r;
    prior_nxt   = prior_r;
    cur_nxt     = cur_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (pix_take) begin
      if (!row_end) begin
        cur_nxt     = cur_new;
        col_cnt_nxt = c + COL_W'(1);
        row_cnt_nxt = r;
      end else if (!frame_end) begin
        older_nxt   = prior_r;
        prior_nxt   = cur_new;
        cur_nxt     = '0;
        col_cnt_nxt = '0;
        row_cnt_nxt = r + ROW_W'(1);
      end else begin
        older_nxt   = '0;
        prior_nxt   = '0;
        cur_nxt     = '0;
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r   <= '0;
      prior_r   <= '0;
      cur_r     <= '0;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      older_r   <= older_nxt;
      prior_r   <= prior_nxt;
      cur_r     <= cur_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

### sv/bod_queue.sv
// ----------------------------------------------------------------------------
// bod_queue
// two-entry job queue between the front end and the pixel back end
// ----------------------------------------------------------------------------
module bod_queue
  import bod_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_push,
  input  bod_job_t  q_wdata,
  output logic      q_full,
  input  logic      q_pop,
  output logic      q_empty,
  output bod_job_t  q_rdata
);

  bod_job_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_rdata = slot_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue count beyond depth");

endmodule

### sv/bod_back.sv
// ----------------------------------------------------------------------------
// bod_back
// expands each job into outline pixels, one per cycle while the output
// register is free or popped, including the row-end columns and the two
// flush rows at frame end; drives the output register
module bod_back
  import bod_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  bod_job_t              q_rdata,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [PIX_W-1:0]      out_value,
  output logic [OUT_ROW_W-1:0]  out_row,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic                  out_last_of_run,
  output logic                  out_frame_done
);

  localparam int EXT_W = MAX_WIDTH + 4;

  logic                  busy_r, busy_nxt;
  logic [MAX_WIDTH-1:0]  older_r, older_nxt;
  logic [MAX_WIDTH-1:0]  prior_r, prior_nxt;
  logic [MAX_WIDTH-1:0]  cur_r, cur_nxt;
  logic [OUT_ROW_W-1:0]  row_r, row_nxt;
  logic [OUT_COL_W-1:0]  col_r, col_nxt;
  logic [OUT_COL_W-1:0]  end_r, end_nxt;
  logic                  fend_r, fend_nxt;
  logic [1:0]            phase_r, phase_nxt;

  logic                  ovalid_r, ovalid_nxt;
  logic [PIX_W-1:0]      oval_r;
  logic [OUT_ROW_W-1:0]  orow_r;
  logic [OUT_COL_W-1:0]  ocol_r;
  logic                  olast_r, odone_r;

  logic                  adv, at_end, job_last, load;
  logic [MAX_WIDTH-1:0]  any_bits;
  logic [EXT_W-1:0]      any_ext, prior_ext;
  logic [2:0]            win;
  logic                  center;
  logic [PIX_W-1:0]      pix;
  logic [OUT_COL_W-1:0]  ld_end;

  assign adv      = busy_r && (!ovalid_r || pop);
  assign at_end   = (col_r == end_r);
  assign job_last = at_end && (!fend_r || (phase_r == 2'd2));
  assign load     = !q_empty && (!busy_r || (adv && job_last));
  assign q_pop    = load;

  // 3x3 window around the center (row-1, col-1) in source coordinates
  always_comb begin
    any_bits  = older_r | prior_r | cur_r;
    any_ext   = {2'b00, any_bits, 2'b00};
    prior_ext = {3'b000, prior_r, 1'b0};
    win       = any_ext[col_r +: 3];
    center    = prior_ext[col_r];
    pix       = ((win != 3'b000) && !center) ? PIX_ON : PIX_OFF;
    ld_end    = OUT_COL_W'(q_rdata.col);
    if (SRC_WIDTH_W'(q_rdata.col) == q_rdata.width - SRC_WIDTH_W'(1)) begin
      ld_end = OUT_COL_W'(q_rdata.width) + OUT_COL_W'(1);
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    older_nxt = older_r;
    prior_nxt = prior_r;
    cur_nxt   = cur_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    end_nxt   = end_r;
    fend_nxt  = fend_r;
    phase_nxt = phase_r;
    if (adv) begin
      if (!at_end) begin
        col_nxt = col_r + OUT_COL_W'(1);
      end else if (!job_last) begin
        // flush row: move the window down one row
        older_nxt = prior_r;
        prior_nxt = cur_r;
        cur_nxt   = '0;
        row_nxt   = row_r + OUT_ROW_W'(1);
        col_nxt   = '0;
        phase_nxt = phase_r + 2'd1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      older_nxt = q_rdata.older;
      prior_nxt = q_rdata.prior;
      cur_nxt   = q_rdata.cur;
      row_nxt   = OUT_ROW_W'(q_rdata.row);
      col_nxt   = OUT_COL_W'(q_rdata.col);
      end_nxt   = ld_end;
      fend_nxt  = q_rdata.frame_end;
      phase_nxt = 2'd0;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (adv) begin
      ovalid_nxt = 1'b1;
    end else if (pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    older_r <= older_nxt;
    prior_r <= prior_nxt;
    cur_r   <= cur_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    end_r   <= end_nxt;
    fend_r  <= fend_nxt;
    if (adv) begin
      oval_r  <= pix;
      orow_r  <= row_r;
      ocol_r  <= col_r;
      olast_r <= job_last;
      odone_r <= job_last && fend_r;
    end
  end

  assign empty           = !ovalid_r;
  assign out_value       = oval_r;
  assign out_row         = orow_r;
  assign out_col         = ocol_r;
  assign out_last_of_run = olast_r;
  assign out_frame_done  = odone_r;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (phase_r != 2'd3))
    else $error("flush phase out of range");

  a_col_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (col_r <= end_r))
    else $error("column ran past end of run");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && odone_r) |-> olast_r)
    else $error("frame done without last of run");

endmodule

### sv/bitmap_outline_dilation_top.sv
// ----------------------------------------------------------------------------
// bitmap_outline_dilation_top
// streaming one-pixel outline of an a8 bitmap, outer ring of a 3x3 dilation
//
// usage:
//   source pixels enter in raster order on in_src_alpha, transferred when
//   push is high and full is low. outline pixels of the (w+2) x (h+2) image
//   leave in raster order with their row and column; a transfer happens when
//   pop is high and empty is low. out_last_of_run marks the last pixel caused
//   by one source pixel, out_frame_done the last pixel of the frame.
//   geometry is set through cfg_we / cfg_index / cfg_data while idle.
// timing:
//   a source pixel reaches the outputs through the job queue, the back-end
//   job registers and the output register. the back end emits one outline
//   pixel per cycle while the output register is free or popped; a row end
//   adds the border columns, the frame end two flush rows; the two-entry job
//   queue absorbs these bursts and full rises only while it holds two jobs.
// reset: masks, counters, queue and output register clear; width 8, height 13.
// stall: while pop is low and the output register is full, it holds and the
//   back end waits; push keeps being taken until the job queue fills.
// ----------------------------------------------------------------------------
module bitmap_outline_dilation_top
  import bod_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [PIX_W-1:0]       in_src_alpha,
  output logic                   empty,
  input  logic                   pop,
  output logic [PIX_W-1:0]       out_value,
  output logic [OUT_ROW_W-1:0]   out_row,
  output logic [OUT_COL_W-1:0]   out_col,
  output logic                   out_last_of_run,
  output logic                   out_frame_done
);

  bod_job_t  front_job, q_job;
  logic      q_full, q_empty, q_pop, pix_take;

  assign full     = q_full;
  assign pix_take = push && !q_full;

  bod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_take  (pix_take),
    .pix_alpha (in_src_alpha),
    .job       (front_job)
  );

  bod_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (pix_take),
    .q_wdata (front_job),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_rdata (q_job)
  );

  bod_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_job),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_value       (out_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the streaming outline dilation block against its own predictor.
// a table of directed steps covers reset geometry, register extremes and
// saturation, ignored register indexes and geometry changes in mid-frame.
// random frames of many sizes follow. sender and receiver idle at random,
// the receiver holds off long enough to fill the block, and every outline
// pixel is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench
  import bod_pkg::*;
();

  localparam int RANDOM_ITEMS    = 400;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 250;
  localparam int TAIL_CYCLES     = 48;
  localparam int MAX_FRAME_ITEMS = 100;
  localparam int DIR_LEN         = 30;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum logic {STEP_PIXEL, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [PIX_W-1:0]       alpha;
    logic                   typed;
    logic [PIX_W-1:0]       t_value;
    logic [OUT_ROW_W-1:0]   t_row;
    logic [OUT_COL_W-1:0]   t_col;
  } dir_step_t;

  typedef struct packed {
    logic [PIX_W-1:0]     value;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
    logic                 done;
  } outline_px_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [PIX_W-1:0]       in_src_alpha = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [PIX_W-1:0]       out_value;
  logic [OUT_ROW_W-1:0]   out_row;
  logic [OUT_COL_W-1:0]   out_col;
  logic                   out_last_of_run;
  logic                   out_frame_done;

  bitmap_outline_dilation_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_src_alpha    (in_src_alpha),
    .empty           (empty),
    .pop             (pop),
    .out_value       (out_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [SRC_WIDTH_W-1:0]  cfg_w = SRC_WIDTH_RESET;
  logic [SRC_HEIGHT_W-1:0] cfg_h = SRC_HEIGHT_RESET;
  logic [MAX_WIDTH-1:0]    older_mask = '0;
  logic [MAX_WIDTH-1:0]    prior_mask = '0;
  logic [MAX_WIDTH-1:0]    cur_mask = '0;
  int                      row_pos = 0;
  int                      col_pos = 0;

  outline_px_t pending_px[$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          stall_cycles = 0;

  dir_step_t dir_tab [DIR_LEN] = '{
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'hFF, 1'b1, PIX_ON,  7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h00, 1'b1, PIX_ON,  7'd0, 5'd1},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h80, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_CFG,   REG_SPARE_LO,   7'h03, 8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_CFG,   REG_SPARE_HI,   7'h7F, 8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h01, 1'b0, PIX_OFF, 7'd0, 5'd0},
    // shrink width in mid-row, then height in mid-frame
    '{STEP_CFG,   REG_SRC_WIDTH,  7'd1,  8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h7F, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_CFG,   REG_SRC_HEIGHT, 7'd1,  8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    // zero registers saturate to one pixel
    '{STEP_CFG,   REG_SRC_WIDTH,  7'd0,  8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_CFG,   REG_SRC_HEIGHT, 7'd0,  8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h01, 1'b1, PIX_ON,  7'd0, 5'd0},
    // low five bits are 31, saturates to full width
    '{STEP_CFG,   REG_SRC_WIDTH,  7'h5F, 8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h00, 1'b1, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'hFF, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h01, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h80, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h02, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h04, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h08, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h10, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h20, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h40, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'hFE, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'hFF, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'h00, 1'b0, PIX_OFF, 7'd0, 5'd0},
    '{STEP_PIXEL, REG_SRC_WIDTH,  7'h00, 8'hFF, 1'b0, PIX_OFF, 7'd0, 5'd0}
  };

  function automatic int eff_width();
    int w;
    w = cfg_w;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = cfg_h;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic void add_px(int row, int col, logic [MAX_WIDTH-1:0] wm);
    logic [31:0] any;
    logic [31:0] win;
    logic [31:0] inner;
    outline_px_t px;
    any   = {16'h0, (older_mask | prior_mask | cur_mask) & wm};
    inner = {16'h0, prior_mask & wm};
    if (col >= 2) win = (any >> (col - 2)) & 32'd7;
    else win = (any << (2 - col)) & 32'd7;
    px.value = (win != 0) ? PIX_ON : PIX_OFF;
    if (col >= 1 && ((inner >> (col - 1)) & 32'd1) != 0) px.value = PIX_OFF;
    px.row  = OUT_ROW_W'(row);
    px.col  = OUT_COL_W'(col);
    px.last = 1'b0;
    px.done = 1'b0;
    pending_px.push_back(px);
  endfunction

  function automatic void roll_rows();
    older_mask = prior_mask;
    prior_mask = cur_mask;
    cur_mask   = '0;
  endfunction

  function automatic void predict_outline(logic [PIX_W-1:0] alpha);
    int w, h, r, c;
    logic [MAX_WIDTH-1:0] wm;
    logic frame_end;
    outline_px_t tail;
    w  = eff_width();
    h  = eff_height();
    wm = MAX_WIDTH'((32'd1 << w) - 32'd1);
    c  = (col_pos < w - 1) ? col_pos : w - 1;
    r  = (row_pos < h - 1) ? row_pos : h - 1;
    frame_end = 1'b0;
    if (alpha != PIX_OFF) cur_mask[c] = 1'b1;
    add_px(r, c, wm);
    if (c == w - 1) begin
      add_px(r, w, wm);
      add_px(r, w + 1, wm);
      roll_rows();
      if (r == h - 1) begin
        for (int k = 0; k <= w + 1; k++) add_px(h, k, wm);
        roll_rows();
        for (int k = 0; k <= w + 1; k++) add_px(h + 1, k, wm);
        older_mask = '0;
        prior_mask = '0;
        cur_mask   = '0;
        row_pos    = 0;
        col_pos    = 0;
        frame_end  = 1'b1;
      end else begin
        row_pos = r + 1;
        col_pos = 0;
      end
    end else begin
      row_pos = r;
      col_pos = c + 1;
    end
    tail      = pending_px.pop_back();
    tail.last = 1'b1;
    tail.done = frame_end;
    pending_px.push_back(tail);
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] alpha, output int first_at);
    if (!no_idle && $urandom_range(0, 99) < 9) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    push         <= 1'b1;
    in_src_alpha <= alpha;
    @(posedge clk);
    while (full) @(posedge clk);
    first_at = pending_px.size();
    predict_outline(alpha);
    items_sent++;
    no_idle = (items_sent >= 200 && items_sent < 300);
  endtask

  task automatic drain_outline();
    @(negedge clk);
    push <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  cfg_w = data[SRC_WIDTH_W-1:0];
      REG_SRC_HEIGHT: cfg_h = data[SRC_HEIGHT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      pop <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      pop <= no_idle || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk) begin
    outline_px_t got;
    outline_px_t want;
    if (rst_n && pop && !empty) begin
      got = {out_value, out_row, out_col, out_last_of_run, out_frame_done};
      if (pending_px.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected outline pixel value %0d row %0d col %0d",
                 $time, out_value, out_row, out_col);
      end else begin
        want = pending_px.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: outline mismatch expected value %0d row %0d col %0d last %0b done %0b",
                   $time, want.value, want.row, want.col, want.last, want.done);
          $display("%0t:                  actual value %0d row %0d col %0d last %0b done %0b",
                   $time, got.value, got.row, got.col, got.last, got.done);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int first_at;
    int n;
    int phase;
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] hd;
    logic [PIX_W-1:0] alpha;
    outline_px_t want;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_LEN; i++) begin
      if (dir_tab[i].kind == STEP_CFG) begin
        drain_outline();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        push_pixel(dir_tab[i].alpha, first_at);
        if (dir_tab[i].typed) begin
          want = pending_px[first_at];
          want.value = dir_tab[i].t_value;
          want.row   = dir_tab[i].t_row;
          want.col   = dir_tab[i].t_col;
          pending_px[first_at] = want;
        end
      end
    end

    phase = 0;
    while (items_sent < DIR_LEN + RANDOM_ITEMS) begin
      case (phase)
        0: begin wd = 7'd1;  hd = 7'h7F; end
        1: begin wd = 7'd16; hd = 7'd2;  end
        2: begin wd = 7'd17; hd = 7'd3;  end
        3: begin wd = 7'd0;  hd = 7'd64; end
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            wd = 7'($urandom_range(0, 127));
            hd = 7'($urandom_range(0, 127));
          end else begin
            wd = 7'($urandom_range(1, 16));
            hd = 7'($urandom_range(1, 6));
          end
        end
      endcase
      drain_outline();
      write_reg(REG_SRC_WIDTH, wd);
      write_reg(REG_SRC_HEIGHT, hd);
      n = eff_width() * eff_height();
      if (phase > 3 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > MAX_FRAME_ITEMS) n = MAX_FRAME_ITEMS;
      // long receiver hold-off while the first tall frame streams in
      if (phase == 0) hold_req = 1'b1;
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: alpha = PIX_OFF;
          4, 5, 6:    alpha = PIX_ON;
          default:    alpha = 8'($urandom_range(0, 255));
        endcase
        push_pixel(alpha, first_at);
      end
      phase++;
    end

    drain_outline();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
sv/bod_pkg.sv
sv/bod_front.sv
sv/bod_queue.sv
sv/bod_back.sv
sv/bitmap_outline_dilation_top.sv
test/testbench.sv
